>>> design/i2c_ebm_pkg.sv
// shared types and constants for the i2c eeprom byte master
// used by i2c_ebm_seq, i2c_eeprom_byte_master and its checker
package i2c_ebm_pkg;

    localparam int unsigned IN_BYTES_W  = 32;
    localparam int unsigned OUT_BYTES_W = 16;

    localparam logic [5:0] SLOT_ACK_DEV   = 6'd9;
    localparam logic [5:0] SLOT_ACK_LOC   = 6'd18;
    localparam logic [5:0] SLOT_ACK_DATA  = 6'd27;
    localparam logic [5:0] SLOT_RESTART   = 6'd19;
    localparam logic [5:0] SLOT_ACK_RDEV  = 6'd28;
    localparam logic [5:0] SLOT_RD_FIRST  = 6'd29;
    localparam logic [5:0] SLOT_RD_LAST   = 6'd36;
    localparam logic [5:0] SLOT_MNACK     = 6'd37;
    localparam logic [5:0] STOP_WRITE     = 6'd28;
    localparam logic [5:0] STOP_READ      = 6'd38;
    localparam logic       RW_READ        = 1'b1;

    typedef enum logic [2:0] {
        KIND_IDLE  = 3'd0,
        KIND_START = 3'd1,
        KIND_DATA  = 3'd2,
        KIND_ACK   = 3'd3,
        KIND_MNACK = 3'd4,
        KIND_STOP  = 3'd5
    } slot_kind_t;

    typedef struct packed {
        logic       req_valid;
        logic       req_type;
        logic [6:0] device_addr;
        logic [7:0] mem_addr;
        logic [7:0] write_data;
        logic       sda_sample;
    } slot_in_t;

    typedef struct packed {
        slot_kind_t slot_kind;
        logic       sda_level;
        logic       busy_res;
        logic       done_res;
        logic       success;
        logic [7:0] read_data;
    } slot_res_t;

endpackage

>>> design/i2c_ebm_seq.sv
// bit-slot sequencer: transaction state and per-slot result logic
// depends on i2c_ebm_pkg
module i2c_ebm_seq
    import i2c_ebm_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      advance,
    input  slot_in_t  slot_in,
    output slot_res_t slot_res
);

    logic       active_reg, active_next;
    logic [5:0] slot_reg, slot_next;
    logic       is_read_reg, is_read_next;
    logic       failed_reg, failed_next;
    logic [6:0] device_reg, device_next;
    logic [7:0] location_reg, location_next;
    logic [7:0] data_reg, data_next;
    logic [7:0] shift_reg, shift_next;
    logic [7:0] gathered_reg, gathered_next;

    logic [5:0] stop_at;
    logic       ack_slot;

    assign stop_at  = is_read_reg ? STOP_READ : STOP_WRITE;
    assign ack_slot = (slot_reg == SLOT_ACK_DEV) || (slot_reg == SLOT_ACK_LOC)
                   || (!is_read_reg && slot_reg == SLOT_ACK_DATA)
                   || (is_read_reg && slot_reg == SLOT_ACK_RDEV);

    always_comb begin
        active_next   = active_reg;
        slot_next     = slot_reg;
        is_read_next  = is_read_reg;
        failed_next   = failed_reg;
        device_next   = device_reg;
        location_next = location_reg;
        data_next     = data_reg;
        shift_next    = shift_reg;
        gathered_next = gathered_reg;
        slot_res      = '{KIND_IDLE, 1'b1, 1'b0, 1'b0, 1'b0, 8'd0};

        if (!active_reg) begin
            if (slot_in.req_valid) begin
                is_read_next  = slot_in.req_type;
                device_next   = slot_in.device_addr;
                location_next = slot_in.mem_addr;
                data_next     = slot_in.write_data;
                shift_next    = {slot_in.device_addr, 1'b0};
                gathered_next = 8'd0;
                failed_next   = 1'b0;
                active_next   = 1'b1;
                slot_next     = 6'd1;
                slot_res      = '{KIND_START, 1'b0, 1'b1, 1'b0, 1'b0, 8'd0};
            end
        end else if (slot_reg >= stop_at) begin
            slot_res = '{KIND_STOP, 1'b1, 1'b1, 1'b1, !failed_reg,
                         (is_read_reg && !failed_reg) ? gathered_reg : 8'd0};
            active_next = 1'b0;
            slot_next   = 6'd0;
        end else if (ack_slot) begin
            slot_res = '{KIND_ACK, 1'b1, 1'b1, 1'b0, 1'b0, 8'd0};
            if (slot_in.sda_sample) begin
                failed_next = 1'b1;
                slot_next   = stop_at;
            end else begin
                if (slot_reg == SLOT_ACK_DEV) begin
                    shift_next = location_reg;
                end else if (slot_reg == SLOT_ACK_LOC && !is_read_reg) begin
                    shift_next = data_reg;
                end
                slot_next = slot_reg + 6'd1;
            end
        end else begin
            if (is_read_reg && slot_reg == SLOT_RESTART) begin
                shift_next = {device_reg, RW_READ};
                slot_res   = '{KIND_START, 1'b0, 1'b1, 1'b0, 1'b0, 8'd0};
            end else if (is_read_reg && slot_reg >= SLOT_RD_FIRST
                         && slot_reg <= SLOT_RD_LAST) begin
                gathered_next = {gathered_reg[6:0], slot_in.sda_sample};
                slot_res      = '{KIND_DATA, 1'b1, 1'b1, 1'b0, 1'b0, 8'd0};
            end else if (is_read_reg && slot_reg == SLOT_MNACK) begin
                slot_res = '{KIND_MNACK, 1'b1, 1'b1, 1'b0, 1'b0, 8'd0};
            end else begin
                shift_next = {shift_reg[6:0], 1'b0};
                slot_res   = '{KIND_DATA, shift_reg[7], 1'b1, 1'b0, 1'b0, 8'd0};
            end
            slot_next = slot_reg + 6'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg   <= 1'b0;
            slot_reg     <= 6'd0;
            is_read_reg  <= 1'b0;
            failed_reg   <= 1'b0;
            device_reg   <= 7'd0;
            location_reg <= 8'd0;
            data_reg     <= 8'd0;
            shift_reg    <= 8'd0;
            gathered_reg <= 8'd0;
        end else if (advance) begin
            active_reg   <= active_next;
            slot_reg     <= slot_next;
            is_read_reg  <= is_read_next;
            failed_reg   <= failed_next;
            device_reg   <= device_next;
            location_reg <= location_next;
            data_reg     <= data_next;
            shift_reg    <= shift_next;
            gathered_reg <= gathered_next;
        end
    end

endmodule

>>> design/i2c_eeprom_byte_master.sv
// top level of the i2c eeprom byte master: stream ports and result register
// depends on i2c_ebm_pkg and i2c_ebm_seq
//
// each input transaction is one bus bit slot; each produces exactly one result
// transaction describing what the master does on the bus in that slot.
// while idle, a slot with req_valid set starts a byte write or a random read
// and is itself the start slot; requests during a transfer are ignored.
// a nack in any acknowledge slot aborts and the next slot is stop with
// success low. done_res, success and read_data appear in the stop slot.
// the result is registered and appears on the master side in the cycle after
// the input transaction is taken. throughput: one slot per cycle while the
// receiver does not stall, set by the single sequencer update between the
// input and the result register. when the receiver stalls, the result
// register holds its contents and the slave side accepts again only as that
// result is taken. reset (aresetn low, synchronous) returns the sequencer to
// idle and empties the result register. a write transfer spans 29 slots, a read 39.
module i2c_eeprom_byte_master
    import i2c_ebm_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // req_valid, req_type, device_addr, mem_addr, write_data, sda_sample
    input  logic [IN_BYTES_W-1:0]  s_axis_tdata,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // slot_kind, sda_level, busy_res, done_res, success, read_data
    output logic [OUT_BYTES_W-1:0] m_axis_tdata
);

    slot_in_t  slot_in;
    slot_res_t slot_res;
    logic      take;
    logic      out_valid_reg;
    slot_res_t out_reg;

    assign slot_in.req_valid   = s_axis_tdata[0];
    assign slot_in.req_type    = s_axis_tdata[1];
    assign slot_in.device_addr = s_axis_tdata[8:2];
    assign slot_in.mem_addr    = s_axis_tdata[16:9];
    assign slot_in.write_data  = s_axis_tdata[24:17];
    assign slot_in.sda_sample  = s_axis_tdata[25];

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign take          = s_axis_tvalid && s_axis_tready;

    i2c_ebm_seq u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .advance  (take),
        .slot_in  (slot_in),
        .slot_res (slot_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (s_axis_tready) begin
            out_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            out_reg <= slot_res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0, out_reg.read_data, out_reg.success, out_reg.done_res,
                            out_reg.busy_res, out_reg.sda_level, out_reg.slot_kind};

endmodule

>>> design/i2c_ebm_check.sv
// port-level checker for the i2c eeprom byte master, bound to the top level
// depends on i2c_ebm_pkg
module i2c_ebm_check
    import i2c_ebm_pkg::*;
(
    input logic                   aclk,
    input logic                   aresetn,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [OUT_BYTES_W-1:0] m_axis_tdata
);

    // empty after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // stalled result holds
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    // done only in a busy stop slot
    a_done_stop: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tdata[5] |->
            m_axis_tdata[2:0] == KIND_STOP && m_axis_tdata[4] && m_axis_tdata[3])
        else $error("done outside stop slot");

    // status fields quiet unless done
    a_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tdata[5] |-> m_axis_tdata[14:6] == 9'd0)
        else $error("success or read data without done");

    // idle slot releases the bus and is not busy
    a_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tdata[2:0] == KIND_IDLE |->
            m_axis_tdata[3] && !m_axis_tdata[4])
        else $error("idle slot drives bus or shows busy");

endmodule

bind i2c_eeprom_byte_master i2c_ebm_check u_check (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
